>>> rtl/tbv_pkg.sv
// ----------------------------------------------------------------------------
// tbv_pkg
// Shared types and constants of the typed bundle validator: status codes,
// the input and result words and the header layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tbv_pkg;

	localparam int unsigned MaxStreamsDefault = 16;

	// header layout: 4 length bytes, 1 width byte, 4 tag bytes
	localparam int unsigned HdrLenBytes = 4;
	localparam int unsigned HdrWidthPos = 4;
	localparam int unsigned HdrLastPos  = 8;
	localparam int unsigned HdrIdxW     = 4;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_HDR_TRUNC  = 3'd1,
		ST_BAD_WIDTH  = 3'd2,
		ST_MISALIGNED = 3'd3,
		ST_DUP_TAG    = 3'd4,
		ST_PAY_TRUNC  = 3'd5,
		ST_EMPTY      = 3'd6,
		ST_TABLE_FULL = 3'd7
	} status_t;

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_END  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		status_t    status;
		logic [4:0] stream_count;
	} out_word_t;

endpackage

`default_nettype wire

>>> rtl/tbv_chan_if.sv
// ----------------------------------------------------------------------------
// tbv_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbv_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/typed_bundle_validator.sv
// ----------------------------------------------------------------------------
// typed_bundle_validator
// Checks a bundle of records (9-byte header plus payload) one byte per word,
// keeps the first error and reports status and, if ok, distinct tag count at the end.
// ----------------------------------------------------------------------------
// flow: a word is registered in the input stage and handled from there; the result
//   of an end word goes to the result register as the end word leaves that stage
// throughput: one word per cycle except in stalls, set by the single update of the
//   record state and the parallel compare against all stored tags on header byte 9
// stalls: an end word waits in the input stage while the last result is unread
// reset: arst_n clears all control state at once; no clearing pass is needed
`default_nettype none

module typed_bundle_validator #(
	parameter int unsigned MAX_STREAMS = tbv_pkg::MaxStreamsDefault
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tbv_chan_if.sink    item,
	tbv_chan_if.source  result
);
	import tbv_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_STREAMS + 1);
	localparam int unsigned IdxW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

	// input stage
	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] byte_s1;

	// record state
	logic               in_payload_q;
	logic [HdrIdxW-1:0] hdr_idx_q;
	logic [31:0]        length_q;
	logic [7:0]         width_q;
	logic [23:0]        tag_q;
	logic [31:0]        payload_left_q;
	logic [31:0]        tag_table_q [MAX_STREAMS];
	logic [CntW-1:0]    tag_count_q;
	status_t            err_q;

	// result register
	logic      out_valid_q;
	out_word_t out_word_q;

	logic out_free;
	logic s1_go;

	// next-state logic
	logic               in_payload_d;
	logic [HdrIdxW-1:0] hdr_idx_d;
	logic [31:0]        payload_left_d;
	logic [CntW-1:0]    tag_count_d;
	status_t            err_d;
	logic               tag_wr;
	logic [31:0]        tag_full;
	logic               tag_hit;
	logic               width_ok;
	logic [2:0]         align_mask;
	status_t            end_status;

	assign out_free   = !out_valid_q || result.ready;
	assign s1_go      = valid_s1 && (mode_s1 == MODE_DATA || out_free);
	assign item.ready = !valid_s1 || s1_go;

	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

	assign tag_full   = {byte_s1, tag_q};
	assign align_mask = width_q[2:0] - 3'd1;

	always_comb begin
		tag_hit = 1'b0;
		for (int i = 0; i < MAX_STREAMS; i++) begin
			if (CntW'(i) < tag_count_q && tag_table_q[i] == tag_full) begin
				tag_hit = 1'b1;
			end
		end
	end

	always_comb begin
		case (width_q) inside
			8'd1, 8'd2, 8'd4, 8'd8: width_ok = 1'b1;
			default:                width_ok = 1'b0;
		endcase
	end

	always_comb begin
		if (err_q != ST_OK) begin
			end_status = err_q;
		end else if (hdr_idx_q != '0) begin
			end_status = ST_HDR_TRUNC;
		end else if (in_payload_q) begin
			end_status = ST_PAY_TRUNC;
		end else if (tag_count_q == '0) begin
			end_status = ST_EMPTY;
		end else begin
			end_status = ST_OK;
		end
	end

	always_comb begin
		in_payload_d   = in_payload_q;
		hdr_idx_d      = hdr_idx_q;
		payload_left_d = payload_left_q;
		tag_count_d    = tag_count_q;
		err_d          = err_q;
		tag_wr         = 1'b0;
		if (mode_s1 == MODE_END) begin
			in_payload_d   = 1'b0;
			hdr_idx_d      = '0;
			payload_left_d = '0;
			tag_count_d    = '0;
			err_d          = ST_OK;
		end else if (err_q != ST_OK) begin
			// bytes after an error are dropped
		end else if (in_payload_q) begin
			payload_left_d = payload_left_q - 32'd1;
			if (payload_left_q == 32'd1) begin
				in_payload_d = 1'b0;
			end
		end else if (hdr_idx_q == HdrIdxW'(HdrLastPos)) begin
			hdr_idx_d = '0;
			if (!width_ok) begin
				err_d = ST_BAD_WIDTH;
			end else if ((length_q[2:0] & align_mask) != 3'd0) begin
				err_d = ST_MISALIGNED;
			end else if (tag_hit) begin
				err_d = ST_DUP_TAG;
			end else if (tag_count_q >= CntW'(MAX_STREAMS)) begin
				err_d = ST_TABLE_FULL;
			end else begin
				tag_wr      = 1'b1;
				tag_count_d = tag_count_q + CntW'(1);
				if (length_q != 32'd0) begin
					in_payload_d   = 1'b1;
					payload_left_d = length_q;
				end
			end
		end else begin
			hdr_idx_d = hdr_idx_q + HdrIdxW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			in_payload_q   <= 1'b0;
			hdr_idx_q      <= '0;
			payload_left_q <= '0;
			tag_count_q    <= '0;
			err_q          <= ST_OK;
			out_valid_q    <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (s1_go) begin
				in_payload_q   <= in_payload_d;
				hdr_idx_q      <= hdr_idx_d;
				payload_left_q <= payload_left_d;
				tag_count_q    <= tag_count_d;
				err_q          <= err_d;
			end
			if (s1_go && mode_s1 == MODE_END) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			mode_s1 <= item.data.mode;
			byte_s1 <= item.data.data_byte;
		end
		if (s1_go && mode_s1 == MODE_DATA && err_q == ST_OK && !in_payload_q) begin
			if (hdr_idx_q < HdrIdxW'(HdrLenBytes)) begin
				length_q[hdr_idx_q[1:0]*8 +: 8] <= byte_s1;
			end else if (hdr_idx_q == HdrIdxW'(HdrWidthPos)) begin
				width_q <= byte_s1;
			end else if (hdr_idx_q < HdrIdxW'(HdrLastPos)) begin
				// tag bytes 0..2; the last one is taken straight from the input stage
				tag_q[(hdr_idx_q[1:0] - 2'd1)*8 +: 8] <= byte_s1;
			end
		end
		if (s1_go && tag_wr) begin
			tag_table_q[tag_count_q[IdxW-1:0]] <= tag_full;
		end
		if (s1_go && mode_s1 == MODE_END) begin
			out_word_q.status       <= end_status;
			out_word_q.stream_count <= (end_status == ST_OK) ? 5'(tag_count_q) : 5'd0;
		end
	end

`ifndef NO_ASSERTIONS
	a_ok_has_tags: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.status == ST_OK |-> result.data.stream_count != 5'd0)
		else $error("ok status with no tags");

	a_err_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.status != ST_OK |-> result.data.stream_count == 5'd0)
		else $error("error status with nonzero count");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> payload_left_q != 32'd0 && hdr_idx_q == '0)
		else $error("payload state inconsistent");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_idx_q <= HdrIdxW'(HdrLastPos) && tag_count_q <= CntW'(MAX_STREAMS))
		else $error("header index or tag count out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/typed_bundle_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_bundle_validator_tb
// Streams bundles of records into the validator word by word. Each accepted
// word also updates a model of the bundle checks kept here, and each end
// word queues the status and tag count the block should report. The result
// channel is compared field by field against that queue. Directed bundles
// cover each status code, then random bundles run with idling on both sides.
// ----------------------------------------------------------------------------

module typed_bundle_validator_tb;

	import tbv_pkg::*;

	localparam int unsigned Streams     = MaxStreamsDefault;
	localparam int unsigned LongHold    = 200;
	localparam int unsigned DrainCycles = 10;

	logic clk;
	logic arst_n;

	tbv_chan_if #(.word_t(in_word_t))  item_ch ();
	tbv_chan_if #(.word_t(out_word_t)) res_ch ();

	typed_bundle_validator #(.MAX_STREAMS(Streams)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch)
	);

	// bundle state as the block should hold it
	logic        mdl_in_pay;
	logic [3:0]  mdl_hdr_pos;
	logic [31:0] mdl_len;
	logic [7:0]  mdl_width;
	logic [31:0] mdl_tag;
	logic [31:0] mdl_pay_left;
	logic [31:0] mdl_tags [Streams];
	logic [4:0]  mdl_tag_total;
	status_t     mdl_first_err;

	out_word_t   expected_reports [$];
	int unsigned failures     = 0;
	int unsigned words_sent   = 0;
	int unsigned reports_seen = 0;
	bit          send_idle    = 1'b1;
	bit          recv_stall   = 1'b1;
	bit          hold_req     = 1'b0;

	out_word_t   exp_w;
	out_word_t   got_w;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic void clear_bundle();
		mdl_in_pay    = 1'b0;
		mdl_hdr_pos   = '0;
		mdl_len       = '0;
		mdl_width     = '0;
		mdl_tag       = '0;
		mdl_pay_left  = '0;
		mdl_tag_total = '0;
		mdl_first_err = ST_OK;
	endfunction

	function automatic void model_word(input in_word_t w);
		status_t    st;
		logic [4:0] cnt;
		bit         dup;
		out_word_t  rpt;
		if (w.mode == MODE_END) begin
			cnt = '0;
			if (mdl_first_err != ST_OK) st = mdl_first_err;
			else if (mdl_hdr_pos != 0) st = ST_HDR_TRUNC;
			else if (mdl_in_pay) st = ST_PAY_TRUNC;
			else if (mdl_tag_total == 0) st = ST_EMPTY;
			else begin
				st  = ST_OK;
				cnt = mdl_tag_total;
			end
			rpt.status       = st;
			rpt.stream_count = cnt;
			expected_reports.insert(expected_reports.size(), rpt);
			clear_bundle();
		end else if (mdl_first_err == ST_OK) begin
			if (mdl_in_pay) begin
				mdl_pay_left = mdl_pay_left - 32'd1;
				if (mdl_pay_left == 0) mdl_in_pay = 1'b0;
			end else begin
				// little-endian fields: shift each byte in from the top
				if (mdl_hdr_pos < HdrWidthPos) mdl_len = {w.data_byte, mdl_len[31:8]};
				else if (mdl_hdr_pos == HdrWidthPos) mdl_width = w.data_byte;
				else mdl_tag = {w.data_byte, mdl_tag[31:8]};
				if (mdl_hdr_pos == HdrLastPos) begin
					mdl_hdr_pos = '0;
					dup = 1'b0;
					for (int i = 0; i < mdl_tag_total; i++)
						if (mdl_tags[i] == mdl_tag) dup = 1'b1;
					if (!(mdl_width inside {8'd1, 8'd2, 8'd4, 8'd8}))
						mdl_first_err = ST_BAD_WIDTH;
					else if ((mdl_len[7:0] & (mdl_width - 8'd1)) != 0)
						mdl_first_err = ST_MISALIGNED;
					else if (dup)
						mdl_first_err = ST_DUP_TAG;
					else if (mdl_tag_total >= Streams)
						mdl_first_err = ST_TABLE_FULL;
					else begin
						mdl_tags[mdl_tag_total] = mdl_tag;
						mdl_tag_total = mdl_tag_total + 5'd1;
						if (mdl_len != 0) begin
							mdl_in_pay   = 1'b1;
							mdl_pay_left = mdl_len;
						end
					end
					mdl_len   = '0;
					mdl_width = '0;
					mdl_tag   = '0;
				end else begin
					mdl_hdr_pos = mdl_hdr_pos + 4'd1;
				end
			end
		end
	endfunction

	// predict on accepted input words, check accepted result words
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) model_word(item_ch.data);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_w = res_ch.data;
			reports_seen++;
			if (expected_reports.size() == 0) begin
				$error("result word with nothing expected: status %0d stream_count %0d",
					got_w.status, got_w.stream_count);
				failures++;
			end else begin
				exp_w = expected_reports.pop_front();
				if (got_w.status !== exp_w.status) begin
					$error("status: expected %0d, actual %0d", exp_w.status, got_w.status);
					failures++;
				end
				if (got_w.stream_count !== exp_w.stream_count) begin
					$error("stream_count: expected %0d, actual %0d",
						exp_w.stream_count, got_w.stream_count);
					failures++;
				end
			end
		end
	end

	// result side: random stalls, and one long hold on request
	initial begin
		res_ch.ready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				hold_req = 1'b0;
			end else if (recv_stall && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_word(input mode_t m, input logic [7:0] b);
		in_word_t w;
		w.mode      = m;
		w.data_byte = b;
		if (send_idle && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do @(posedge clk); while (!item_ch.ready);
		words_sent++;
	endtask

	// first hdr_n header bytes, then npay random payload bytes
	task automatic send_record(input logic [31:0] len, input logic [7:0] wid,
			input logic [31:0] tag, input int unsigned hdr_n, input int unsigned npay);
		logic [71:0] hdr;
		hdr = {tag, wid, len};
		for (int i = 0; i < hdr_n; i++) send_word(MODE_DATA, hdr[8*i +: 8]);
		repeat (npay) send_word(MODE_DATA, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_empty_bundle();
		send_word(MODE_END, 8'hFF);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_well_formed();
		send_record(32'd3, 8'd1, 32'h0000_0000, 9, 3);
		send_record(32'd4, 8'd2, 32'hFFFF_FFFF, 9, 4);
		send_record(32'd8, 8'd4, 32'h8000_0000, 9, 8);
		send_record(32'd16, 8'd8, 32'h0000_0001, 9, 16);
		send_record(32'd0, 8'd8, 32'h7FFF_FFFF, 9, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_truncated_header();
		send_record(32'd2, 8'd1, 32'hA5A5_A5A5, 5, 0);
		send_word(MODE_END, 8'h00);
		send_record(32'd0, 8'd1, 32'h0000_0010, 9, 0);
		send_record(32'd0, 8'd1, 32'h0000_0011, 8, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_bad_width();
		send_record(32'd0, 8'd0, 32'h1, 9, 0);
		send_word(MODE_END, 8'h00);
		send_record(32'd5, 8'd3, 32'h2, 9, 0);   // bad width is checked before alignment; width 3 is not 1, 2, 4 or 8
		send_word(MODE_END, 8'h00);
		send_record(32'd16, 8'd255, 32'h3, 9, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_misaligned();
		send_record(32'd6, 8'd4, 32'h1, 9, 0);
		send_word(MODE_END, 8'h00);
		send_record(32'd1, 8'd8, 32'h2, 9, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_duplicate_tag();
		send_record(32'd2, 8'd2, 32'hDEAD_BEEF, 9, 2);
		send_record(32'd0, 8'd1, 32'hDEAD_BEEF, 9, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_truncated_payload();
		send_record(32'hFFFF_FFFF, 8'd1, 32'h5, 9, 3);
		send_word(MODE_END, 8'h00);
		send_record(32'hFFFF_FFF8, 8'd8, 32'h6, 9, 15);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < Streams; i++) send_record(32'd0, 8'd1, 32'h1000 + i, 9, 0);
		send_word(MODE_END, 8'h00);
		for (int i = 0; i < Streams; i++) send_record(32'd0, 8'd1, 32'h1000 + i, 9, 0);
		send_record(32'd0, 8'd1, 32'h2000, 9, 0);
		send_word(MODE_END, 8'h00);
		// a repeated tag is reported ahead of a full table
		for (int i = 0; i < Streams; i++) send_record(32'd0, 8'd1, 32'h1000 + i, 9, 0);
		send_record(32'd0, 8'd1, 32'h1000, 9, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_sticky_error();
		send_record(32'd4, 8'd7, 32'h1, 9, 0);
		send_record(32'd4, 8'd4, 32'h2, 9, 4);
		send_record(32'd3, 8'd2, 32'h3, 6, 0);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		// short bundles so end words pile up behind the stalled result side
		for (int i = 0; i < 16; i++) begin
			send_word(MODE_END, 8'h00);
			send_record(32'd0, 8'd1, 32'($urandom), 9, 0);
			send_word(MODE_END, 8'h00);
		end
	endtask

	task automatic test_random_bundles(input int unsigned n_words, input int unsigned n_reports);
		int unsigned w0;
		int unsigned r0;
		int unsigned kind;
		int unsigned nrec;
		int unsigned hdr_n;
		int unsigned npay;
		int unsigned pick;
		logic [31:0] len;
		logic [7:0]  wid;
		logic [31:0] tag;
		bit          cut;
		w0 = words_sent;
		r0 = reports_seen;
		while (words_sent - w0 < n_words || reports_seen - r0 < n_reports) begin
			kind = $urandom_range(0, 15);
			if (kind == 0) begin
				repeat ($urandom_range(0, 20)) send_word(MODE_DATA, 8'($urandom_range(0, 255)));
			end else begin
				nrec = (kind == 1) ? $urandom_range(14, 18) : $urandom_range(1, 3);
				cut  = 1'b0;
				for (int r = 0; r < nrec && !cut; r++) begin
					if ($urandom_range(0, 15) == 0) wid = 8'($urandom_range(0, 255));
					else wid = 8'(1 << $urandom_range(0, 3));
					pick = $urandom_range(0, 15);
					if (pick == 0) len = $urandom;
					else if (pick == 1) len = $urandom_range(0, 40);
					else len = wid * $urandom_range(0, (kind == 1) ? 1 : 3);
					npay = (len <= 64) ? len : $urandom_range(0, 8);
					case ($urandom_range(0, 15))
						0:       tag = 32'h0000_0000;
						1:       tag = 32'hFFFF_FFFF;
						2, 3:    tag = $urandom_range(0, 3);
						default: tag = $urandom;
					endcase
					hdr_n = 9;
					if ($urandom_range(0, 19) == 0) begin
						hdr_n = $urandom_range(1, 8);
						npay  = 0;
						cut   = 1'b1;
					end else if (npay > 0 && $urandom_range(0, 19) == 0) begin
						npay = $urandom_range(0, npay - 1);
						cut  = 1'b1;
					end
					send_record(len, wid, tag, hdr_n, npay);
				end
			end
			send_word(MODE_END, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		clear_bundle();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_bundle();
		test_well_formed();
		test_truncated_header();
		test_bad_width();
		test_misaligned();
		test_duplicate_tag();
		test_truncated_payload();
		test_table_full();
		test_sticky_error();
		test_backpressure();
		test_random_bundles(850, 15);
		send_idle  = 1'b0;
		recv_stall = 1'b0;
		test_random_bundles(180, 4);

		item_ch.valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (failures == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/tbv_pkg.sv
rtl/tbv_chan_if.sv
rtl/typed_bundle_validator.sv
tb/sv/typed_bundle_validator_tb.sv
